// ===== sv/dsc_pkg.sv =====
package dsc_pkg;

    localparam int WORDS        = 64;
    localparam int MAX_WORD_LEN = 20;
    localparam int SYM_W        = 8;

    // word slot index, word count (holds WORDS itself), symbol position, word length
    localparam int WORD_IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WORD_CNT_W = $clog2(WORDS + 1);
    localparam int POS_W      = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LEN_W      = $clog2(MAX_WORD_LEN + 1);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_WORD  = 2'd1,
        ACT_TEXT  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // one dictionary word travelling down the cell chain
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [WORD_IDX_W-1:0] idx;
        logic [LEN_W-1:0]      len;
        logic                  match;
    } t_token;

    // symbol write into the column of one cell
    typedef struct packed {
        logic                  en;
        logic [POS_W-1:0]      pos;
        logic [WORD_IDX_W-1:0] addr;
        logic [SYM_W-1:0]      data;
    } t_wr;

endpackage

// ===== sv/dsc_in_if.sv =====
interface dsc_in_if;
    import dsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output action, output symbol, output last, input ready);
    modport sink   (input valid, input action, input symbol, input last, output ready);
endinterface

// ===== sv/dsc_out_if.sv =====
interface dsc_out_if;
    logic valid;
    logic ready;
    logic segmentable;
    logic text_end;

    modport source (output valid, output segmentable, output text_end, input ready);
    modport sink   (input valid, input segmentable, input text_end, output ready);
endinterface

// ===== sv/dsc_cell.sv =====
module dsc_cell (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic [dsc_pkg::POS_W-1:0]                            i_pos,
    input  dsc_pkg::t_wr                                         i_wr,
    input  logic                                                 i_shift,
    input  logic                                                 i_hclr,
    input  logic [dsc_pkg::SYM_W-1:0]                            i_win_in,
    input  logic [dsc_pkg::MAX_WORD_LEN-1:0][dsc_pkg::SYM_W-1:0] i_win_all,
    input  dsc_pkg::t_token                                      i_tok,
    output dsc_pkg::t_token                                      o_tok,
    output logic [dsc_pkg::SYM_W-1:0]                            o_win
);
    import dsc_pkg::*;

    logic [SYM_W-1:0] r_col [WORDS];
    logic [SYM_W-1:0] r_data;
    logic [SYM_W-1:0] r_win;
    t_token           r_tok;
    logic             w_used;
    logic [LEN_W-1:0] w_sel;
    logic             w_hit;

    // symbol column of every word at this position
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.pos == i_pos)) begin
            r_col[i_wr.addr] <= i_wr.data;
        end
        r_data <= r_col[i_tok.idx];
    end

    // text window tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_hclr) begin
            r_win <= '0;
        end else if (i_shift) begin
            r_win <= i_win_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // word symbol at this position lines up with window entry len-1-pos
    assign w_used = LEN_W'(i_pos) < r_tok.len;
    assign w_sel  = r_tok.len - LEN_W'(i_pos) - LEN_W'(1);
    assign w_hit  = !w_used || (r_data == i_win_all[w_sel[POS_W-1:0]]);

    always_comb begin
        o_tok       = r_tok;
        o_tok.match = r_tok.match && w_hit;
    end

    assign o_win = r_win;

endmodule

// ===== sv/dsc_seq.sv =====
module dsc_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  logic                              i_word,
    input  logic [dsc_pkg::SYM_W-1:0]         i_symbol,
    input  logic                              i_last,
    input  logic                              i_start,
    input  logic [dsc_pkg::MAX_WORD_LEN-1:0]  i_reach,
    output logic                              o_empty,
    output dsc_pkg::t_wr                      o_wr,
    output dsc_pkg::t_token                   o_tok
);
    import dsc_pkg::*;

    logic [LEN_W:0]          r_len_mem [WORDS];
    logic [LEN_W:0]          r_len_rd;
    logic [WORD_CNT_W-1:0]   r_word_count;
    logic [LEN_W-1:0]        r_load_pos;
    logic                    r_cur_inv;
    logic                    r_busy;
    logic [WORD_CNT_W-1:0]   r_issue;
    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic [WORD_IDX_W-1:0]   r_s1_idx;

    logic                    w_room;
    logic                    w_fits;
    logic                    w_load;
    logic [LEN_W-1:0]        w_pos_next;
    logic                    w_inv;
    logic                    w_issue_last;
    logic [LEN_W-1:0]        w_len;
    logic [LEN_W-1:0]        w_lm1;

    assign w_room     = r_word_count < WORD_CNT_W'(WORDS);
    assign w_fits     = r_load_pos < LEN_W'(MAX_WORD_LEN);
    assign w_load     = i_word && w_room;
    assign w_pos_next = w_fits ? r_load_pos + LEN_W'(1) : r_load_pos;
    assign w_inv      = r_cur_inv || !w_fits;

    always_comb begin
        o_wr.en   = w_load && w_fits;
        o_wr.pos  = r_load_pos[POS_W-1:0];
        o_wr.addr = r_word_count[WORD_IDX_W-1:0];
        o_wr.data = i_symbol;
    end

    // dictionary bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_word_count <= '0;
            r_load_pos   <= '0;
            r_cur_inv    <= 1'b0;
        end else if (w_load) begin
            if (i_last) begin
                r_word_count <= r_word_count + WORD_CNT_W'(1);
                r_load_pos   <= '0;
                r_cur_inv    <= 1'b0;
            end else begin
                r_load_pos <= w_pos_next;
                r_cur_inv  <= w_inv;
            end
        end
    end

    // length and invalid flag per word
    always_ff @(posedge i_clk) begin
        if (w_load && i_last) begin
            r_len_mem[r_word_count[WORD_IDX_W-1:0]] <= {w_inv, w_pos_next};
        end
        r_len_rd <= r_len_mem[r_issue[WORD_IDX_W-1:0]];
    end

    assign w_issue_last = (r_issue + WORD_CNT_W'(1)) == r_word_count;

    // one stored word into the chain per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_issue    <= '0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= r_busy;
            r_s1_last  <= r_busy && w_issue_last;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_issue <= '0;
            end else if (r_busy) begin
                r_issue <= r_issue + WORD_CNT_W'(1);
                if (w_issue_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_issue[WORD_IDX_W-1:0];
    end

    assign w_len = r_len_rd[LEN_W-1:0];
    assign w_lm1 = (w_len == '0) ? '0 : w_len - LEN_W'(1);

    // a word can only close here if the text before it was reachable
    always_comb begin
        o_tok.valid = r_s1_valid;
        o_tok.last  = r_s1_last;
        o_tok.idx   = r_s1_idx;
        o_tok.len   = w_len;
        o_tok.match = !r_len_rd[LEN_W] && (w_len != '0) && i_reach[w_lm1[POS_W-1:0]];
    end

    assign o_empty = r_word_count == '0;

endmodule

// ===== sv/dictionary_segmentation_checker.sv =====
// a word or clear transfer keeps the input ready; a text symbol is evaluated by streaming the
// stored words one per cycle through the MAX_WORD_LEN-cell chain before the result transfer,
// or goes straight to the result with an empty dictionary
// the next input is taken from the cycle in which the result enters the output register
// reset (synchronous, active low) empties the dictionary and the text history;
// the word symbol store needs no clearing pass
module dictionary_segmentation_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsc_in_if.sink      i_in,
    dsc_out_if.source   o_out
);
    import dsc_pkg::*;

    t_state                            r_state;
    t_state                            n_state;
    logic                              r_acc;
    logic                              n_acc;
    logic                              r_res;
    logic                              n_res;
    logic                              r_fin;
    logic                              n_fin;
    logic [MAX_WORD_LEN-1:0]           r_reach;
    logic [MAX_WORD_LEN-1:0]           n_reach;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic                              r_out_seg;
    logic                              n_out_seg;
    logic                              r_out_end;
    logic                              n_out_end;

    logic                              w_xfer;
    logic                              w_clear;
    logic                              w_word;
    logic                              w_text;
    logic                              w_start;
    logic                              w_hclr;
    logic                              w_empty;
    t_wr                               w_wr;
    t_token                            w_tok [MAX_WORD_LEN+1];
    t_token                            w_tail;
    logic [MAX_WORD_LEN-1:0][SYM_W-1:0] w_win;

    // input transfers only while no text symbol is being evaluated
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_xfer     = i_in.valid && i_in.ready;

    // action decode, unused code is dropped
    always_comb begin
        w_clear = 1'b0;
        w_word  = 1'b0;
        w_text  = 1'b0;
        unique case (i_in.action)
            ACT_CLEAR: w_clear = w_xfer;
            ACT_WORD:  w_word  = w_xfer;
            ACT_TEXT:  w_text  = w_xfer;
            default: ;
        endcase
    end

    // dictionary bookkeeping and word issue
    dsc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_clear),
        .i_word   (w_word),
        .i_symbol (i_in.symbol),
        .i_last   (i_in.last),
        .i_start  (w_start),
        .i_reach  (r_reach),
        .o_empty  (w_empty),
        .o_wr     (w_wr),
        .o_tok    (w_tok[0])
    );

    // chain of cells: cell g holds text window entry g and symbol g of every word;
    // a word token visits one cell per cycle and loses its match on a mismatch
    for (genvar g = 0; g < MAX_WORD_LEN; g++) begin : g_cell
        logic [SYM_W-1:0] w_win_in;

        if (g == 0) begin : g_head
            assign w_win_in = i_in.symbol;
        end else begin : g_body
            assign w_win_in = w_win[g-1];
        end

        dsc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_pos     (POS_W'(g)),
            .i_wr      (w_wr),
            .i_shift   (w_text),
            .i_hclr    (w_hclr),
            .i_win_in  (w_win_in),
            .i_win_all (w_win),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1]),
            .o_win     (w_win[g])
        );
    end

    assign w_tail = w_tok[MAX_WORD_LEN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= 1'b0;
            r_res       <= 1'b0;
            r_fin       <= 1'b0;
            r_reach     <= MAX_WORD_LEN'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_res       <= n_res;
            r_fin       <= n_fin;
            r_reach     <= n_reach;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_seg <= n_out_seg;
        r_out_end <= n_out_end;
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_res       = r_res;
        n_fin       = r_fin;
        n_reach     = r_reach;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_seg   = r_out_seg;
        n_out_end   = r_out_end;
        w_start     = 1'b0;
        w_hclr      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_text) begin
                    n_acc = 1'b0;
                    n_fin = i_in.last;
                    if (w_empty) begin
                        // nothing to match against
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        w_start = 1'b1;
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                // or of all word matches as they leave the chain
                if (w_tail.valid) begin
                    n_acc = r_acc || w_tail.match;
                    if (w_tail.last) begin
                        n_res   = r_acc || w_tail.match;
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // wait for a free output register, then update history
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_seg   = r_res;
                    n_out_end   = r_fin;
                    n_state     = ST_IDLE;
                    if (r_fin) begin
                        n_reach = MAX_WORD_LEN'(1);
                        w_hclr  = 1'b1;
                    end else begin
                        n_reach = (r_reach << 1) | MAX_WORD_LEN'(r_res);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.segmentable = r_out_seg;
    assign o_out.text_end    = r_out_end;

endmodule
